@@ rtl/qrm_pkg.sv @@
`default_nettype none
package qrm_pkg;

  // Default fraction width of the fixed-point components.
  localparam int FRAC_BITS_DEF = 14;
  // Squared length of four 16-bit components needs up to 33 bits (at most 2^32).
  localparam int LEN_W = 33;
  // Signed numerators get two bits more than the squared length.
  localparam int NUM_W = LEN_W + 2;
  // Nine matrix elements.
  localparam int LANES = 9;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               zero_length;
  } matrix_t;

  // Control that travels alongside each request through the pipeline.
  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

endpackage
`default_nettype wire

@@ rtl/qrm_front.sv @@
`default_nettype none
module qrm_front #(
  parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire qrm_pkg::quat_t      req,
  output qrm_pkg::ctl_t            ctl,
  output logic [qrm_pkg::LEN_W-1:0] len2,
  output logic [qrm_pkg::LANES-1:0] neg,
  output logic [qrm_pkg::LEN_W+FRAC_BITS:0] rem [qrm_pkg::LANES]
);
  import qrm_pkg::*;

  localparam int DW = LEN_W + FRAC_BITS + 1;

  // Stage 1: the ten products.
  logic v1;
  logic signed [31:0] p_xx, p_yy, p_zz, p_ww, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    p_xx <= req.quat_x * req.quat_x;
    p_yy <= req.quat_y * req.quat_y;
    p_zz <= req.quat_z * req.quat_z;
    p_ww <= req.quat_w * req.quat_w;
    p_xy <= req.quat_x * req.quat_y;
    p_xz <= req.quat_x * req.quat_z;
    p_yz <= req.quat_y * req.quat_z;
    p_wx <= req.quat_w * req.quat_x;
    p_wy <= req.quat_w * req.quat_y;
    p_wz <= req.quat_w * req.quat_z;
  end

  // Stage 2: squared length and the nine numerators.
  logic signed [NUM_W-1:0] e_xx, e_yy, e_zz, e_ww, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
  logic signed [NUM_W-1:0] l2s;
  logic signed [NUM_W-1:0] num_next [LANES];

  assign e_xx = NUM_W'(p_xx);
  assign e_yy = NUM_W'(p_yy);
  assign e_zz = NUM_W'(p_zz);
  assign e_ww = NUM_W'(p_ww);
  assign e_xy = NUM_W'(p_xy);
  assign e_xz = NUM_W'(p_xz);
  assign e_yz = NUM_W'(p_yz);
  assign e_wx = NUM_W'(p_wx);
  assign e_wy = NUM_W'(p_wy);
  assign e_wz = NUM_W'(p_wz);
  assign l2s  = e_xx + e_yy + e_zz + e_ww;

  always_comb begin
    num_next[0] = e_xx + e_ww - e_yy - e_zz;
    num_next[1] = (e_xy - e_wz) <<< 1;
    num_next[2] = (e_xz + e_wy) <<< 1;
    num_next[3] = (e_xy + e_wz) <<< 1;
    num_next[4] = e_yy + e_ww - e_zz - e_xx;
    num_next[5] = (e_yz - e_wx) <<< 1;
    num_next[6] = (e_xz - e_wy) <<< 1;
    num_next[7] = (e_yz + e_wx) <<< 1;
    num_next[8] = e_zz + e_ww - e_xx - e_yy;
  end

  logic v2;
  logic [LEN_W-1:0] l2_2;
  logic signed [NUM_W-1:0] num [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    l2_2 <= l2s[LEN_W-1:0];
    num  <= num_next;
  end

  // Stage 3: sign and magnitude, dividend with the rounding half added.
  logic [NUM_W-1:0] mag [LANES];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      mag[k] = num[k][NUM_W-1] ? NUM_W'(-num[k]) : NUM_W'(num[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= v2;
    end
    ctl.zero <= (l2_2 == '0);
    len2     <= l2_2;
    for (int k = 0; k < LANES; k++) begin
      neg[k] <= num[k][NUM_W-1];
      rem[k] <= (DW'(mag[k][LEN_W-1:0]) << FRAC_BITS) + DW'(l2_2 >> 1);
    end
  end

endmodule
`default_nettype wire

@@ rtl/qrm_div_stage.sv @@
`default_nettype none
module qrm_div_stage #(
  parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEF,
  parameter int BIT       = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire qrm_pkg::ctl_t                 ctl_in,
  input  wire logic [qrm_pkg::LEN_W-1:0]     len2_in,
  input  wire logic [qrm_pkg::LANES-1:0]     neg_in,
  input  wire logic [qrm_pkg::LEN_W+FRAC_BITS:0] rem_in [qrm_pkg::LANES],
  input  wire logic [FRAC_BITS:0]            quo_in [qrm_pkg::LANES],
  output qrm_pkg::ctl_t                      ctl_out,
  output logic [qrm_pkg::LEN_W-1:0]          len2_out,
  output logic [qrm_pkg::LANES-1:0]          neg_out,
  output logic [qrm_pkg::LEN_W+FRAC_BITS:0]  rem_out [qrm_pkg::LANES],
  output logic [FRAC_BITS:0]                 quo_out [qrm_pkg::LANES]
);
  import qrm_pkg::*;

  localparam int DW = LEN_W + FRAC_BITS + 1;
  localparam int QW = FRAC_BITS + 1;

  logic [DW-1:0] trial;
  logic [LANES-1:0] take;

  assign trial = DW'(len2_in) << BIT;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      take[k] = (rem_in[k] >= trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.zero <= ctl_in.zero;
    len2_out     <= len2_in;
    neg_out      <= neg_in;
    for (int k = 0; k < LANES; k++) begin
      rem_out[k] <= take[k] ? rem_in[k] - trial : rem_in[k];
      quo_out[k] <= {quo_in[k][QW-2:0], take[k]};
    end
  end

endmodule
`default_nettype wire

@@ rtl/qrm_output.sv @@
`default_nettype none
module qrm_output #(
  parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire qrm_pkg::ctl_t             ctl,
  input  wire logic [qrm_pkg::LANES-1:0] neg,
  input  wire logic [FRAC_BITS:0]        quo [qrm_pkg::LANES],
  output logic                           done,
  output qrm_pkg::matrix_t               rsp
);
  import qrm_pkg::*;

  localparam int QW = FRAC_BITS + 1;
  localparam logic [QW-1:0] OUT_LIM = (FRAC_BITS > 14) ? QW'(32767) : (QW'(1) << FRAC_BITS);

  logic [15:0] el [LANES];
  logic [QW-1:0] sat;

  always_comb begin
    sat = '0;
    for (int k = 0; k < LANES; k++) begin
      sat   = (quo[k] > OUT_LIM) ? OUT_LIM : quo[k];
      el[k] = neg[k] ? 16'(-sat) : 16'(sat);
    end
    if (ctl.zero) begin
      for (int k = 0; k < LANES; k++) begin
        el[k] = '0;
      end
      el[0] = 16'(OUT_LIM);
      el[4] = 16'(OUT_LIM);
      el[8] = 16'(OUT_LIM);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid;
    end
    rsp.m00         <= el[0];
    rsp.m01         <= el[1];
    rsp.m02         <= el[2];
    rsp.m10         <= el[3];
    rsp.m11         <= el[4];
    rsp.m12         <= el[5];
    rsp.m20         <= el[6];
    rsp.m21         <= el[7];
    rsp.m22         <= el[8];
    rsp.zero_length <= ctl.zero;
  end

endmodule
`default_nettype wire

@@ rtl/quaternion_to_rotation_matrix.sv @@
`default_nettype none
// Quaternion to rotation matrix. A request carries one quaternion (x, y, z, w) in signed
// fixed point with FRAC_BITS fraction bits and need not be of unit length; the result is
// the nine elements of the 3x3 rotation matrix, row-major, each rounded once to nearest
// (ties away from zero) and saturated to plus or minus one. An all-zero quaternion gives
// the identity matrix with zero_length set. The block is never busy: a request may be
// issued with start in every clock cycle, and each result appears on rsp for exactly one
// cycle with done high. The receiver cannot hold results off, so it must take each one
// in the cycle it is shown. The divider resolves one quotient bit per pipeline stage
// for all nine elements in parallel, behind three front stages (products, numerators,
// dividend) and one output stage for saturation.
module quaternion_to_rotation_matrix #(
  parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire qrm_pkg::quat_t   req,
  output logic                  done,
  output qrm_pkg::matrix_t      rsp
);
  import qrm_pkg::*;

  localparam int DW = LEN_W + FRAC_BITS + 1;
  localparam int QW = FRAC_BITS + 1;
  localparam logic [15:0] LIM16 = (FRAC_BITS > 14) ? 16'(32767) : (16'(1) << FRAC_BITS);

  // Every stage advances in every cycle, so requests are never refused.
  assign busy = 1'b0;

  // Divider chain: entry s carries the state going into divider stage s.
  ctl_t            ctl_s  [QW+1];
  logic [LEN_W-1:0] len2_s [QW+1];
  logic [LANES-1:0] neg_s  [QW+1];
  logic [DW-1:0]    rem_s  [QW+1][LANES];
  logic [QW-1:0]    quo_s  [QW+1][LANES];

  qrm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .ctl   (ctl_s[0]),
    .len2  (len2_s[0]),
    .neg   (neg_s[0]),
    .rem   (rem_s[0])
  );

  // The quotient bits are shifted in at the bottom, most significant first, so the first stage starts from zero.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      quo_s[0][k] = '0;
    end
  end

  // Stage s decides quotient bit FRAC_BITS - s; the quotient never exceeds one bit
  // above the fraction because every numerator is bounded by the squared length.
  for (genvar s = 0; s < QW; s++) begin : g_div
    qrm_div_stage #(.FRAC_BITS(FRAC_BITS), .BIT(FRAC_BITS - s)) u_stage (
      .clk      (clk),
      .rst      (rst),
      .ctl_in   (ctl_s[s]),
      .len2_in  (len2_s[s]),
      .neg_in   (neg_s[s]),
      .rem_in   (rem_s[s]),
      .quo_in   (quo_s[s]),
      .ctl_out  (ctl_s[s+1]),
      .len2_out (len2_s[s+1]),
      .neg_out  (neg_s[s+1]),
      .rem_out  (rem_s[s+1]),
      .quo_out  (quo_s[s+1])
    );
  end

  qrm_output #(.FRAC_BITS(FRAC_BITS)) u_output (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl_s[QW]),
    .neg  (neg_s[QW]),
    .quo  (quo_s[QW]),
    .done (done),
    .rsp  (rsp)
  );

  // A zero-length request must give the identity diagonal and zeros in m01, m12 and m20.
  a_identity: assert property (@(posedge clk) disable iff (rst)
    done && rsp.zero_length |-> rsp.m00 == LIM16 && rsp.m11 == LIM16 && rsp.m22 == LIM16
      && rsp.m01 == 16'd0 && rsp.m12 == 16'd0 && rsp.m20 == 16'd0)
    else $error("zero-length request did not give the identity");

  // Saturation keeps every diagonal element within plus or minus one; m00 and m22 are checked.
  a_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.m00 <= $signed(LIM16) && rsp.m00 >= -$signed(LIM16)
      && rsp.m22 <= $signed(LIM16) && rsp.m22 >= -$signed(LIM16))
    else $error("matrix element beyond saturation limit");

  // A valid bit that enters the divider must leave it after passing every divider stage.
  a_chain: assert property (@(posedge clk) disable iff (rst)
    ctl_s[0].valid |-> ##(QW) ctl_s[QW].valid)
    else $error("request lost in the divider pipeline");

endmodule
`default_nettype wire
